@@ hdl/iir_direct_form_two_filter_top_macros.svh @@
// Assertion macros shared by the filter modules.
`ifndef IIR_DIRECT_FORM_TWO_FILTER_TOP_MACROS_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_TOP_MACROS_SVH

// Clocked assertion on aclk, off while aresetn is low.
`define IIR_ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Same-cycle implication.
`define IIR_ASSERT_IMPL(label, ante, cons, msg) \
    `IIR_ASSERT_PROP(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define IIR_ASSERT_NEXT(label, ante, cons, msg) \
    `IIR_ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

@@ hdl/iirdf2_pkg.sv @@
// Shared types and constants of the direct form II filter.
`default_nettype none

package iirdf2_pkg;

    localparam int DATA_W     = 32;
    localparam int SAMPLE_W   = 24;
    localparam int ORDER_W    = 2;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam int MAX_ORDER_DEF      = 2;
    localparam int COEF_FRAC_BITS_DEF = 28;

    localparam logic [DATA_W-1:0] FWD0_RESET = 32'h1000_0000;

    localparam logic [REG_IDX_W-1:0] REG_FWD0     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FWD1     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FWD2     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FB1      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB2      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FWD_ORD  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FB_ORD   = 3'd6;

    typedef struct packed {
        logic signed [DATA_W-1:0] fwd0;
        logic signed [DATA_W-1:0] fwd1;
        logic signed [DATA_W-1:0] fwd2;
        logic signed [DATA_W-1:0] fb1;
        logic signed [DATA_W-1:0] fb2;
        logic [ORDER_W-1:0]       fwd_order;
        logic [ORDER_W-1:0]       fb_order;
    } cfg_t;

    typedef struct packed {
        logic               mul_en;
        logic               mul_fb;
        logic [ORDER_W-1:0] tap;
        logic               acc_load;
        logic               acc_clear;
        logic               w_latch;
        logic               y_latch;
        logic [ORDER_W-1:0] span;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ hdl/iirdf2_cfg.sv @@
// Coefficient and order registers behind the register port.
`default_nettype none

module iirdf2_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [iirdf2_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [iirdf2_pkg::DATA_W-1:0]     pwdata,
    output logic      [iirdf2_pkg::DATA_W-1:0]     prdata,
    output logic                                   pready,
    output iirdf2_pkg::cfg_t                       cfg
);
    import iirdf2_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fwd0      <= FWD0_RESET;
            cfg_reg.fwd1      <= '0;
            cfg_reg.fwd2      <= '0;
            cfg_reg.fb1       <= '0;
            cfg_reg.fb2       <= '0;
            cfg_reg.fwd_order <= '0;
            cfg_reg.fb_order  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FWD0:    cfg_reg.fwd0      <= pwdata;
                REG_FWD1:    cfg_reg.fwd1      <= pwdata;
                REG_FWD2:    cfg_reg.fwd2      <= pwdata;
                REG_FB1:     cfg_reg.fb1       <= pwdata;
                REG_FB2:     cfg_reg.fb2       <= pwdata;
                REG_FWD_ORD: cfg_reg.fwd_order <= pwdata[ORDER_W-1:0];
                REG_FB_ORD:  cfg_reg.fb_order  <= pwdata[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FWD0:    prdata = cfg_reg.fwd0;
            REG_FWD1:    prdata = cfg_reg.fwd1;
            REG_FWD2:    prdata = cfg_reg.fwd2;
            REG_FB1:     prdata = cfg_reg.fb1;
            REG_FB2:     prdata = cfg_reg.fb2;
            REG_FWD_ORD: prdata = {{(DATA_W-ORDER_W){1'b0}}, cfg_reg.fwd_order};
            REG_FB_ORD:  prdata = {{(DATA_W-ORDER_W){1'b0}}, cfg_reg.fb_order};
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/iirdf2_dp.sv @@
// Datapath: shared multiplier, rounding accumulator, saturation and delay line.
`default_nettype none

module iirdf2_dp #(
    parameter int MAX_ORDER      = iirdf2_pkg::MAX_ORDER_DEF,
    parameter int COEF_FRAC_BITS = iirdf2_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire iirdf2_pkg::cfg_t                       cfg,
    input  wire iirdf2_pkg::dp_cmd_t                    cmd,
    input  wire logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed      [iirdf2_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                        clipped
);
    import iirdf2_pkg::*;

    localparam int PROD_W   = 2 * DATA_W;
    localparam int Q_W      = PROD_W - COEF_FRAC_BITS;
    localparam int ACC_W    = Q_W + 3;
    localparam int DL_IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    logic signed [DATA_W-1:0]   dl_reg [MAX_ORDER];
    logic signed [DATA_W-1:0]   w_reg;
    logic                       clip_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_valid_reg;
    logic                       prod_sub_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       clipped_reg;

    logic signed [DATA_W-1:0]   mul_a;
    logic signed [DATA_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   prod_full;
    logic [DL_IDX_W-1:0]        dl_idx;
    logic signed [ACC_W-1:0]    q_ext;
    logic signed [ACC_W-1:0]    addend;
    logic                       cin;
    logic [ACC_W-1:0]           acc_sum;
    logic                       w_ovf;
    logic signed [DATA_W-1:0]   w_sat;
    logic                       y_ovf;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign dl_idx = DL_IDX_W'(cmd.tap - ORDER_W'(1));

    // Pick the coefficient and the value for this tap.
    always_comb begin
        if (cmd.mul_fb) begin
            mul_a = (cmd.tap == ORDER_W'(1)) ? cfg.fb1 : cfg.fb2;
        end else begin
            case (cmd.tap)
                2'd0:    mul_a = cfg.fwd0;
                2'd1:    mul_a = cfg.fwd1;
                default: mul_a = cfg.fwd2;
            endcase
        end
        if (!cmd.mul_fb && cmd.tap == '0) begin
            mul_b = w_reg;
        end else begin
            mul_b = dl_reg[dl_idx];
        end
    end

    assign prod_full = mul_a * mul_b;

    // Round to nearest: floor(p / 2^F) plus bit F-1, folded in as a carry.
    assign q_ext = ACC_W'($signed(prod_reg[PROD_W-1:COEF_FRAC_BITS]));

    always_comb begin
        if (prod_valid_reg) begin
            addend = prod_sub_reg ? ~q_ext : q_ext;
            cin    = prod_sub_reg ? ~prod_reg[COEF_FRAC_BITS-1]
                                  : prod_reg[COEF_FRAC_BITS-1];
        end else begin
            addend = '0;
            cin    = 1'b0;
        end
    end

    assign acc_sum = acc_reg + addend + {{(ACC_W-1){1'b0}}, cin};

    assign w_ovf = !((&acc_sum[ACC_W-1:DATA_W-1]) || !(|acc_sum[ACC_W-1:DATA_W-1]));
    assign w_sat = w_ovf ? (acc_sum[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}})
                         : acc_sum[DATA_W-1:0];

    assign y_ovf = !((&acc_sum[ACC_W-1:SAMPLE_W-1]) || !(|acc_sum[ACC_W-1:SAMPLE_W-1]));
    assign y_sat = y_ovf ? (acc_sum[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                             : {1'b0, {(SAMPLE_W-1){1'b1}}})
                         : acc_sum[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg     <= prod_full;
            prod_sub_reg <= cmd.mul_fb;
        end
        if (cmd.acc_load) begin
            acc_reg <= ACC_W'(sample_in);
        end else if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_sum;
        end
        if (cmd.w_latch) begin
            w_reg    <= w_sat;
            clip_reg <= w_ovf;
        end
        if (cmd.y_latch) begin
            sample_out_reg <= y_sat;
            clipped_reg    <= clip_reg || y_ovf;
        end
    end

    // Shift only the taps in use; w enters the first one.
    for (genvar j = 0; j < MAX_ORDER; j++) begin : g_dl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dl_reg[j] <= '0;
            end else if (cmd.y_latch && cmd.span > ORDER_W'(j)) begin
                if (j == 0) begin
                    dl_reg[j] <= w_reg;
                end else begin
                    dl_reg[j] <= dl_reg[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule

`default_nettype wire

@@ hdl/iirdf2_ctrl.sv @@
// Sequencer: steps the shared multiplier over the taps and runs the handshakes.
`default_nettype none

`include "iir_direct_form_two_filter_top_macros.svh"

module iirdf2_ctrl #(
    parameter int MAX_ORDER = iirdf2_pkg::MAX_ORDER_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire iirdf2_pkg::cfg_t    cfg,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output iirdf2_pkg::dp_cmd_t      cmd
);
    import iirdf2_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FB   = 3'd1;
    localparam logic [2:0] S_WSAT = 3'd2;
    localparam logic [2:0] S_FW   = 3'd3;
    localparam logic [2:0] S_YSAT = 3'd4;

    localparam logic [ORDER_W-1:0] ORD_MAX = ORDER_W'(MAX_ORDER);

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [ORDER_W-1:0] tap_reg;
    logic [ORDER_W-1:0] tap_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;

    logic [ORDER_W-1:0] nfb;
    logic [ORDER_W-1:0] nfw;
    logic               accept;
    logic               out_free;

    assign nfb      = (cfg.fb_order > ORD_MAX) ? ORD_MAX : cfg.fb_order;
    assign nfw      = (cfg.fwd_order > ORD_MAX) ? ORD_MAX : cfg.fwd_order;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        cmd           = '0;
        cmd.tap       = tap_reg;
        cmd.span      = (nfb > nfw) ? nfb : nfw;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.acc_load = 1'b1;
                    tap_next     = ORDER_W'(1);
                    state_next   = (nfb != '0) ? S_FB : S_WSAT;
                end
            end
            S_FB: begin
                cmd.mul_en = 1'b1;
                cmd.mul_fb = 1'b1;
                if (tap_reg == nfb) begin
                    state_next = S_WSAT;
                end else begin
                    tap_next = tap_reg + ORDER_W'(1);
                end
            end
            S_WSAT: begin
                // Last feedback product lands here; latch w and restart the sum.
                cmd.w_latch   = 1'b1;
                cmd.acc_clear = 1'b1;
                tap_next      = '0;
                state_next    = S_FW;
            end
            S_FW: begin
                cmd.mul_en = 1'b1;
                if (tap_reg == nfw) begin
                    state_next = S_YSAT;
                end else begin
                    tap_next = tap_reg + ORDER_W'(1);
                end
            end
            S_YSAT: begin
                // Hold until the output register is free.
                if (out_free) begin
                    cmd.y_latch   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tap_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `IIR_ASSERT_NEXT(a_accept_starts, accept, state_reg == S_FB || state_reg == S_WSAT, "request did not start the feedback pass")
    `IIR_ASSERT_IMPL(a_fb_tap_range, state_reg == S_FB, tap_reg != '0 && tap_reg <= nfb, "feedback tap out of range")
    `IIR_ASSERT_IMPL(a_no_overwrite, cmd.y_latch, !m_tvalid_reg || m_tready, "result overwritten before it was taken")
    `IIR_ASSERT_NEXT(a_result_shown, cmd.y_latch, m_tvalid_reg && state_reg == S_IDLE, "latched result not presented")

endmodule

`default_nettype wire

@@ hdl/iir_direct_form_two_filter_top.sv @@
// Top level of the second-order direct form II IIR filter.
//
//   channel   direction  handshake               payload
//   s_        in         s_tvalid / s_tready     s_tdata: sample_in
//   m_        out        m_tvalid / m_tready     m_tdata: sample_out, m_tuser: clipped
//   apb       in         psel, penable, pwrite   paddr, pwdata, prdata
//
// A sample occupies the filter longer the higher its feedback and forward orders (an order
// of three acts as two), and no new sample is taken until the filter is back in idle. This
// is set by the single shared 32x32 multiplier that steps through the taps one product
// per cycle, each summed in the cycle after.
// Reset is synchronous on aresetn low, clears the delay line and restores the default
// coefficients and orders.
// A result waits in the output register; the next sample is taken meanwhile, and
// the filter stalls at its final step only while that register is still full.
`default_nettype none

module iir_direct_form_two_filter_top #(
    parameter int MAX_ORDER      = iirdf2_pkg::MAX_ORDER_DEF,
    parameter int COEF_FRAC_BITS = iirdf2_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [iirdf2_pkg::SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [iirdf2_pkg::SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
    output logic                                   m_tuser,   // [0] clipped
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [iirdf2_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [iirdf2_pkg::DATA_W-1:0]     pwdata,
    output logic      [iirdf2_pkg::DATA_W-1:0]     prdata,
    output logic                                   pready
);
    import iirdf2_pkg::*;

    cfg_t                       cfg;
    dp_cmd_t                    cmd;
    logic signed [SAMPLE_W-1:0] sample_out;

    iirdf2_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    iirdf2_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    iirdf2_dp #(
        .MAX_ORDER      (MAX_ORDER),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cmd        (cmd),
        .sample_in  (s_tdata),
        .sample_out (sample_out),
        .clipped    (m_tuser)
    );

    assign m_tdata = sample_out;

endmodule

`default_nettype wire
